// ----- hdl/vfv_pkg.sv -----
// vfv_pkg: grid geometry, codes, shared types and helpers for the voxel face
// visibility block. Used by vfv_grid_ram, vfv_seq and voxel_face_visibility.
// No dependencies.
package vfv_pkg;

   // grid geometry and cell width
   localparam int GRID_X    = 16;
   localparam int GRID_Y    = 256;
   localparam int GRID_Z    = 16;
   localparam int TYPE_BITS = 8;

   // fixed field widths of the stream beats
   localparam int MODE_W  = 2;
   localparam int XW      = 4;
   localparam int YW      = 8;
   localparam int ZW      = 4;
   localparam int NEW_W   = 8;
   localparam int AIR_W   = 8;
   localparam int MASK_W  = 6;
   localparam int COUNT_W = 3;
   localparam int CTYPE_W = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int STEP_W     = 3;

   typedef logic [TYPE_BITS-1:0] voxel_type;
   typedef logic [IDX_W-1:0]     cell_idx_type;
   typedef logic [STEP_W-1:0]    step_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_QUERY,
      ST_DONE
   } seq_state_type;

   // query read order: center, then neighbors in face-mask bit order
   localparam step_type STEP_CENTER = 3'd0;
   localparam step_type STEP_PY     = 3'd1;
   localparam step_type STEP_MY     = 3'd2;
   localparam step_type STEP_PZ     = 3'd3;
   localparam step_type STEP_MZ     = 3'd4;
   localparam step_type STEP_PX     = 3'd5;
   localparam step_type STEP_MX     = 3'd6;

   typedef struct packed {
      logic         we;
      cell_idx_type waddr;
      voxel_type    wdata;
      logic         re;
      cell_idx_type raddr;
   } ram_req_type;

   typedef struct packed {
      logic idle;
      logic filling;
   } seq_status_type;

   typedef struct packed {
      logic [CTYPE_W-1:0] cell_type;
      logic               visible;
      logic [COUNT_W-1:0] face_count;
      logic [MASK_W-1:0]  face_mask;
   } rsp_type;

   // linear index: (x * GRID_Y + y) * GRID_Z + z
   function automatic cell_idx_type cell_index(input logic [XW:0] x,
                                               input logic [YW:0] y,
                                               input logic [ZW:0] z);
      logic [31:0] lin;
      lin = (32'(x) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_Z) + 32'(z);
      return IDX_W'(lin);
   endfunction

   function automatic logic [COUNT_W-1:0] popcount6(input logic [MASK_W-1:0] m);
      logic [COUNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < MASK_W; i++) begin
         c = c + COUNT_W'(m[i]);
      end
      return c;
   endfunction

endpackage

// ----- hdl/voxel_face_visibility.sv -----
// voxel_face_visibility: top level. Holds the air-code register and the
// result register, wires vfv_seq to vfv_grid_ram. Depends on vfv_pkg.
//
// Usage:
//   req_* carries command beats: tuser is the mode (write cell, fill grid,
//   query cell), tdata the cell coordinates and the new type code. Every
//   accepted beat yields exactly one rsp_* beat; writes and fills answer with
//   all-zero fields, a query answers with the exposed-face mask, its count,
//   the visible flag and the stored type code.
//   One command is in work at a time; req_tready is high only while idle.
//   Work each command does before its result is registered:
//     write cell:   one RAM write
//     query cell:   up to seven reads (center and six neighbors) in turn
//                   through the one RAM read port; off-grid neighbors skip their read
//     fill grid:    CELL_COUNT RAM writes, one RAM write per cycle
//   A finished result sits in the output register; the next command is
//   accepted meanwhile and waits at its end until rsp_tready frees the slot.
//   csr_we writes the air code (reset value 0); write it only while idle.
//   Reset clears control state only. The grid RAM is not cleared: a fill
//   sweep or writes must cover every cell a query will touch.
module voxel_face_visibility (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,     // air_code
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // cell_x[3:0], cell_y[11:4], cell_z[15:12],
                                      // new_type[23:16]
   input  logic [1:0]  req_tuser,     // mode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata      // face_mask[5:0], face_count[8:6], visible[9],
                                      // cell_type[17:10], zero[23:18]
);

   logic [vfv_pkg::AIR_W-1:0] air_code_ff;
   logic                      rsp_valid_ff;
   vfv_pkg::rsp_type          rsp_data_ff;

   vfv_pkg::ram_req_type      ram_req;
   vfv_pkg::voxel_type        rd_data;
   vfv_pkg::seq_status_type   seq_status;
   vfv_pkg::rsp_type          res;
   logic                      res_push;
   logic                      out_free;

   // air code register
   always_ff @(posedge clock) begin
      if (reset) begin
         air_code_ff <= '0;
      end else if (csr_we) begin
         air_code_ff <= csr_wdata;
      end
   end

   // output slot is free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   vfv_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_mode     (vfv_pkg::mode_type'(req_tuser)),
      .req_x        (req_tdata[3:0]),
      .req_y        (req_tdata[11:4]),
      .req_z        (req_tdata[15:12]),
      .req_new_type (req_tdata[23:16]),
      .air_code     (air_code_ff),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .ram_req      (ram_req),
      .status       (seq_status),
      .res_push     (res_push),
      .res          (res)
   );

   vfv_grid_ram u_grid_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_tready = seq_status.idle;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.cell_type, rsp_data_ff.visible,
                        rsp_data_ff.face_count, rsp_data_ff.face_mask};

   // a command beat always moves the sequencer out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sequencer still ready after accepting a command");

   // no command is taken during a fill sweep
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      seq_status.filling |-> !req_tready)
      else $error("ready raised during fill sweep");

   // visible flag agrees with the face count
   a_visible_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.visible == (rsp_data_ff.face_count != '0)))
      else $error("visible flag disagrees with face count");

   // count matches the mask it was taken from
   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.face_count == vfv_pkg::popcount6(rsp_data_ff.face_mask)))
      else $error("face count does not match face mask");

endmodule

// ----- hdl/vfv_grid_ram.sv -----
// vfv_grid_ram: voxel type store, one write port and one registered read port.
// Depends on vfv_pkg.
module vfv_grid_ram (
   input  logic                clock,
   input  vfv_pkg::ram_req_type ram_req,
   output vfv_pkg::voxel_type  rd_data
);

   vfv_pkg::voxel_type mem_ff [vfv_pkg::CELL_COUNT];
   vfv_pkg::voxel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem_ff[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= mem_ff[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/vfv_seq.sv -----
// vfv_seq: command sequencer. Runs writes, fill sweeps and the seven-read
// neighbor scan of a query against the grid RAM. Depends on vfv_pkg.
module vfv_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  vfv_pkg::mode_type             req_mode,
   input  logic [vfv_pkg::XW-1:0]        req_x,
   input  logic [vfv_pkg::YW-1:0]        req_y,
   input  logic [vfv_pkg::ZW-1:0]        req_z,
   input  logic [vfv_pkg::NEW_W-1:0]     req_new_type,
   input  logic [vfv_pkg::AIR_W-1:0]     air_code,
   input  logic                          out_free,
   input  vfv_pkg::voxel_type            rd_data,
   output vfv_pkg::ram_req_type          ram_req,
   output vfv_pkg::seq_status_type       status,
   output logic                          res_push,
   output vfv_pkg::rsp_type              res
);

   vfv_pkg::seq_state_type state_ff, state_in;
   vfv_pkg::step_type      iss_ff, iss_in;
   logic                   rd_vld_ff, rd_vld_in;
   vfv_pkg::step_type      rd_step_ff;
   logic                   rd_out_ff;
   vfv_pkg::cell_idx_type  fill_cnt_ff, fill_cnt_in;
   vfv_pkg::voxel_type     fill_type_ff, fill_type_in;
   logic [vfv_pkg::XW-1:0] x_ff, x_in;
   logic [vfv_pkg::YW-1:0] y_ff, y_in;
   logic [vfv_pkg::ZW-1:0] z_ff, z_in;
   logic [vfv_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic                   solid_ff, solid_in;
   vfv_pkg::voxel_type     ctype_ff, ctype_in;

   vfv_pkg::voxel_type     air_t;
   logic                   accept;
   logic                   in_grid;
   logic                   issue;
   logic                   nb_out;
   logic [vfv_pkg::XW:0]   nx;
   logic [vfv_pkg::YW:0]   ny;
   logic [vfv_pkg::ZW:0]   nz;
   logic [vfv_pkg::MASK_W-1:0] mask_gated;

   assign air_t   = vfv_pkg::TYPE_BITS'(air_code);
   assign accept  = req_valid && (state_ff == vfv_pkg::ST_IDLE);
   assign in_grid = (32'(req_x) < vfv_pkg::GRID_X) && (32'(req_y) < vfv_pkg::GRID_Y) &&
                    (32'(req_z) < vfv_pkg::GRID_Z);
   assign issue   = (state_ff == vfv_pkg::ST_QUERY) && (iss_ff <= vfv_pkg::STEP_MX);

   // neighbor coordinate for the current read step; off-grid steps skip the read
   always_comb begin
      nx     = {1'b0, x_ff};
      ny     = {1'b0, y_ff};
      nz     = {1'b0, z_ff};
      nb_out = 1'b0;
      case (iss_ff)
         vfv_pkg::STEP_PY: begin
            ny     = {1'b0, y_ff} + 1'b1;
            nb_out = 32'(ny) >= vfv_pkg::GRID_Y;
         end
         vfv_pkg::STEP_MY: begin
            ny     = {1'b0, y_ff} - 1'b1;
            nb_out = (y_ff == '0);
         end
         vfv_pkg::STEP_PZ: begin
            nz     = {1'b0, z_ff} + 1'b1;
            nb_out = 32'(nz) >= vfv_pkg::GRID_Z;
         end
         vfv_pkg::STEP_MZ: begin
            nz     = {1'b0, z_ff} - 1'b1;
            nb_out = (z_ff == '0);
         end
         vfv_pkg::STEP_PX: begin
            nx     = {1'b0, x_ff} + 1'b1;
            nb_out = 32'(nx) >= vfv_pkg::GRID_X;
         end
         vfv_pkg::STEP_MX: begin
            nx     = {1'b0, x_ff} - 1'b1;
            nb_out = (x_ff == '0);
         end
         default: begin
            nb_out = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      rd_vld_in    = issue && !nb_out;
      fill_cnt_in  = fill_cnt_ff;
      fill_type_in = fill_type_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      mask_in      = mask_ff;
      solid_in     = solid_ff;
      ctype_in     = ctype_ff;
      ram_req      = '0;
      res_push     = 1'b0;

      case (state_ff)
         vfv_pkg::ST_IDLE: begin
            if (accept) begin
               x_in     = req_x;
               y_in     = req_y;
               z_in     = req_z;
               mask_in  = '0;
               solid_in = 1'b0;
               ctype_in = '0;
               iss_in   = vfv_pkg::STEP_CENTER;
               case (req_mode)
                  vfv_pkg::MODE_WRITE: begin
                     ram_req.we    = in_grid;
                     ram_req.waddr = vfv_pkg::cell_index({1'b0, req_x}, {1'b0, req_y},
                                                         {1'b0, req_z});
                     ram_req.wdata = vfv_pkg::TYPE_BITS'(req_new_type);
                     state_in      = vfv_pkg::ST_DONE;
                  end
                  vfv_pkg::MODE_FILL: begin
                     fill_cnt_in  = '0;
                     fill_type_in = vfv_pkg::TYPE_BITS'(req_new_type);
                     state_in     = vfv_pkg::ST_FILL;
                  end
                  vfv_pkg::MODE_QUERY: begin
                     state_in = in_grid ? vfv_pkg::ST_QUERY : vfv_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = vfv_pkg::ST_DONE;
                  end
               endcase
            end
         end
         vfv_pkg::ST_FILL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = fill_cnt_ff;
            ram_req.wdata = fill_type_ff;
            fill_cnt_in   = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == vfv_pkg::IDX_W'(vfv_pkg::CELL_COUNT - 1)) begin
               state_in = vfv_pkg::ST_DONE;
            end
         end
         vfv_pkg::ST_QUERY: begin
            if (issue) begin
               ram_req.re    = !nb_out;
               ram_req.raddr = vfv_pkg::cell_index(nx, ny, nz);
               iss_in        = iss_ff + 1'b1;
            end
            // off-grid neighbors count as air without a read
            if (issue && nb_out) begin
               mask_in[3'(iss_ff - 3'd1)] = 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_step_ff == vfv_pkg::STEP_CENTER) begin
                  ctype_in = rd_data;
                  solid_in = (rd_data != air_t);
               end else if (rd_data == air_t) begin
                  mask_in[3'(rd_step_ff - 3'd1)] = 1'b1;
               end
            end
            // last step is -x: done once it is read or skipped
            if ((rd_vld_ff && rd_step_ff == vfv_pkg::STEP_MX) ||
                (issue && nb_out && iss_ff == vfv_pkg::STEP_MX)) begin
               state_in = vfv_pkg::ST_DONE;
            end
         end
         vfv_pkg::ST_DONE: begin
            if (out_free) begin
               res_push = 1'b1;
               state_in = vfv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vfv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vfv_pkg::ST_IDLE;
         iss_ff    <= vfv_pkg::STEP_CENTER;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iss_ff    <= iss_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff   <= iss_ff;
      rd_out_ff    <= nb_out;
      fill_cnt_ff  <= fill_cnt_in;
      fill_type_ff <= fill_type_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      mask_ff      <= mask_in;
      solid_ff     <= solid_in;
      ctype_ff     <= ctype_in;
   end

   assign mask_gated     = solid_ff ? mask_ff : '0;
   assign res.face_mask  = mask_gated;
   assign res.face_count = vfv_pkg::popcount6(mask_gated);
   assign res.visible    = (mask_gated != '0);
   assign res.cell_type  = vfv_pkg::CTYPE_W'(ctype_ff);

   assign status.idle    = (state_ff == vfv_pkg::ST_IDLE);
   assign status.filling = (state_ff == vfv_pkg::ST_FILL) && !rd_out_ff;

endmodule

// ----- sim/voxel_face_visibility_tb.sv -----
// voxel_face_visibility_tb: self-checking bench for the voxel face visibility block.
// Runs a directed command table, then per air code a fill and random write/query/reserved
// traffic, and checks each rsp beat against a grid model kept here. Needs vfv_pkg.
module voxel_face_visibility_tb;

   // watchdog limit on stretches with no beat on either side: outlasts several grid fills
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_CYCLES    = 300;   // long rsp back-pressure stretch
   localparam int DRAIN_CYCLES   = 20;    // quiet time after the drain for a stray beat
   localparam int PHASE_ITEMS    = 250;
   localparam int NUM_PHASES     = 4;
   localparam int PLAN_ROWS      = 24;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [5:0] mask;
      logic [2:0] count;
      logic       vis;
      logic [7:0] ctype;
   } face_rsp_type;

   typedef struct {
      vfv_pkg::mode_type mode;
      logic [3:0]        x;
      logic [7:0]        y;
      logic [3:0]        z;
      logic [7:0]        ntype;
      bit                typed;     // 1: expectation below is fixed, else predicted
      face_rsp_type      rsp;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // cell_x[3:0], cell_y[11:4], cell_z[15:12], new_type[23:16]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // face_mask[5:0], face_count[8:6], visible[9],
                             // cell_type[17:10], zero[23:18]

   // model state: grid contents and the air code
   logic [7:0]  voxel_map [vfv_pkg::CELL_COUNT];
   logic [7:0]  air_model;

   face_rsp_type pending_faces[$];
   int           mismatches;
   int           idle_cycles;
   bit           hold_req;
   bit           hold_done;
   bit           no_gaps;

   plan_row_type plan [PLAN_ROWS];

   voxel_face_visibility u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Grid model
   // ---------------------------------------------------------------------------

   // outside the grid counts as air
   function automatic bit is_open(input int px, input int py, input int pz);
      if (px < 0 || py < 0 || pz < 0 || px >= vfv_pkg::GRID_X || py >= vfv_pkg::GRID_Y ||
          pz >= vfv_pkg::GRID_Z)
         return 1'b1;
      return voxel_map[(px * vfv_pkg::GRID_Y + py) * vfv_pkg::GRID_Z + pz] == air_model;
   endfunction

   // applies one command to the model and returns the beat it should produce
   function automatic face_rsp_type predict_faces(input vfv_pkg::mode_type m,
                                                  input logic [3:0] x,
                                                  input logic [7:0] y, input logic [3:0] z,
                                                  input logic [7:0] t);
      face_rsp_type r;
      int           sx;
      int           sy;
      int           sz;
      r  = '0;
      sx = int'(x);
      sy = int'(y);
      sz = int'(z);
      case (m)
         vfv_pkg::MODE_WRITE: begin
            voxel_map[(sx * vfv_pkg::GRID_Y + sy) * vfv_pkg::GRID_Z + sz] = t;
         end
         vfv_pkg::MODE_FILL: begin
            foreach (voxel_map[i]) voxel_map[i] = t;
         end
         vfv_pkg::MODE_QUERY: begin
            r.ctype = voxel_map[(sx * vfv_pkg::GRID_Y + sy) * vfv_pkg::GRID_Z + sz];
            if (!is_open(sx, sy, sz)) begin
               // bit order: +y -y +z -z +x -x
               r.mask[0] = is_open(sx, sy + 1, sz);
               r.mask[1] = is_open(sx, sy - 1, sz);
               r.mask[2] = is_open(sx, sy, sz + 1);
               r.mask[3] = is_open(sx, sy, sz - 1);
               r.mask[4] = is_open(sx + 1, sy, sz);
               r.mask[5] = is_open(sx - 1, sy, sz);
               r.count   = 3'($countones(r.mask));
               r.vis     = (r.count != 0);
            end
         end
         default: begin
            // reserved mode: no state change, all-zero beat
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one command beat; entered and left at a falling edge
   task automatic issue(input vfv_pkg::mode_type m, input logic [3:0] x,
                        input logic [7:0] y, input logic [3:0] z, input logic [7:0] t,
                        input bit typed, input face_rsp_type typed_rsp);
      face_rsp_type p;
      int           gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = m;
      req_tdata  = {t, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted: advance the model in acceptance order
      p = predict_faces(m, x, y, z, t);
      pending_faces.push_back(typed ? typed_rsp : p);
      @(negedge clock);
   endtask

   // block must be idle: every command answers, so an empty queue means done
   task automatic write_air(input logic [7:0] code);
      req_tvalid = 1'b0;
      while (pending_faces.size() != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = code;
      @(negedge clock);
      csr_we    = 1'b0;
      air_model = code;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [7:0]        air_set  [NUM_PHASES];
      logic [7:0]        fill_set [NUM_PHASES];
      logic [3:0]        hx;
      logic [7:0]        hy;
      logic [3:0]        hz;
      logic [3:0]        x;
      logic [7:0]        y;
      logic [3:0]        z;
      logic [7:0]        t;
      vfv_pkg::mode_type m;
      int                r;

      clock      = 1'b0;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      air_model  = '0;
      mismatches = 0;
      hold_req   = 1'b0;
      no_gaps    = 1'b0;
      foreach (voxel_map[i]) voxel_map[i] = '0;

      // directed table; fixed expectations where the answer is obvious
      plan = '{
         // clear the grid first: nothing may be read before it is written
         '{vfv_pkg::MODE_FILL,  4'd0,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd0,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         // lone solid at the low corner: all six faces exposed
         '{vfv_pkg::MODE_WRITE, 4'd0,  8'd0,   4'd0,  8'hFF, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd0,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd63, 3'd6, 1'b1, 8'hFF}},
         // lone solid at the high corner
         '{vfv_pkg::MODE_WRITE, 4'd15, 8'd255, 4'd15, 8'hAA, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd15, 8'd255, 4'd15, 8'hFF, 1'b1, '{6'd63, 3'd6, 1'b1, 8'hAA}},
         // two solids side by side along x hide each other's shared face
         '{vfv_pkg::MODE_WRITE, 4'd1,  8'd0,   4'd0,  8'h01, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd0,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd47, 3'd5, 1'b1, 8'hFF}},
         '{vfv_pkg::MODE_QUERY, 4'd1,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd31, 3'd5, 1'b1, 8'h01}},
         // reserved mode with every field high: zero beat, grid untouched
         '{vfv_pkg::MODE_RSVD,  4'd15, 8'd255, 4'd15, 8'hFF, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd1,  8'd0,   4'd0,  8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}},
         // solid fill: interior fully hidden, corners show their outward faces
         '{vfv_pkg::MODE_FILL,  4'd0,  8'd0,   4'd0,  8'h5A, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd7,  8'd128, 4'd7,  8'h00, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h5A}},
         '{vfv_pkg::MODE_QUERY, 4'd0,  8'd0,   4'd0,  8'h00, 1'b1, '{6'd42, 3'd3, 1'b1, 8'h5A}},
         '{vfv_pkg::MODE_QUERY, 4'd15, 8'd255, 4'd15, 8'h00, 1'b1, '{6'd21, 3'd3, 1'b1, 8'h5A}},
         // punch one air hole and look at it from above, below and inside
         '{vfv_pkg::MODE_WRITE, 4'd8,  8'd100, 4'd8,  8'h00, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd8,  8'd101, 4'd8,  8'h00, 1'b1, '{6'd2,  3'd1, 1'b1, 8'h5A}},
         '{vfv_pkg::MODE_QUERY, 4'd8,  8'd99,  4'd8,  8'h00, 1'b1, '{6'd1,  3'd1, 1'b1, 8'h5A}},
         '{vfv_pkg::MODE_QUERY, 4'd8,  8'd100, 4'd8,  8'h00, 1'b1, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_WRITE, 4'd9,  8'd100, 4'd8,  8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd10, 8'd100, 4'd8,  8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_WRITE, 4'd8,  8'd100, 4'd9,  8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd8,  8'd100, 4'd10, 8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}},
         '{vfv_pkg::MODE_QUERY, 4'd9,  8'd100, 4'd8,  8'h00, 1'b0, '{6'd0,  3'd0, 1'b0, 8'h00}}
      };

      // air codes per phase: both extremes plus two random ones;
      // fills give all-air, all-solid, all-air, then a random starting grid
      air_set  = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'($urandom_range(0, 255))};
      fill_set = '{8'hFF, 8'h77, 8'h00, 8'h00};
      fill_set[2] = air_set[2];
      fill_set[3] = 8'($urandom_range(0, 255));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i])
         issue(plan[i].mode, plan[i].x, plan[i].y, plan[i].z, plan[i].ntype,
               plan[i].typed, plan[i].rsp);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_air(air_set[ph]);
         no_gaps = (ph == 1);   // one phase with a sender that never pauses
         issue(vfv_pkg::MODE_FILL, 4'($urandom), 8'($urandom), 4'($urandom), fill_set[ph],
               1'b0, '0);
         // traffic clusters in a small corner-ish box so neighbors interact
         hx = $urandom_range(0, 1) ? 4'd12 : 4'd0;
         hy = 8'($urandom_range(0, 2) * 126);
         hz = $urandom_range(0, 1) ? 4'd12 : 4'd0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 40) hold_req = 1'b1;
            r = $urandom_range(0, 99);
            m = (r < 3) ? vfv_pkg::MODE_RSVD :
                (r < 48) ? vfv_pkg::MODE_WRITE : vfv_pkg::MODE_QUERY;
            if ($urandom_range(0, 99) < 75) begin
               x = hx + 4'($urandom_range(0, 3));
               y = hy + 8'($urandom_range(0, 3));
               z = hz + 4'($urandom_range(0, 3));
            end else begin
               x = 4'($urandom);
               y = 8'($urandom);
               z = 4'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 40)      t = air_model;
            else if (r < 70) t = $urandom_range(0, 1) ? 8'h11 : 8'h22;
            else             t = 8'($urandom);
            issue(m, x, y, z, t, 1'b0, '0);
         end
      end

      // drain, then let any stray beat show up
      req_tvalid = 1'b0;
      while (pending_faces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_faces.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------------
   initial begin
      int r;
      int len;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            // hold long enough that the block backs up and stalls req
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready = 1'b1;
               len = $urandom_range(1, 20);
            end else if (r < 95) begin
               rsp_tready = 1'b0;
               len = $urandom_range(1, 4);
            end else begin
               rsp_tready = 1'b0;
               len = $urandom_range(20, 60);
            end
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t rsp %s: expected %0h actual %0h", $realtime, what, exp_v, act_v);
   endtask

   // check every accepted rsp beat against the oldest pending expectation
   always @(posedge clock) begin
      face_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_faces.size() == 0) begin
            note_mismatch("beat with nothing pending, tdata", 8'h00, rsp_tdata[7:0]);
         end else begin
            e = pending_faces.pop_front();
            if (rsp_tdata[5:0] !== e.mask)
               note_mismatch("face_mask", 8'(e.mask), 8'(rsp_tdata[5:0]));
            if (rsp_tdata[8:6] !== e.count)
               note_mismatch("face_count", 8'(e.count), 8'(rsp_tdata[8:6]));
            if (rsp_tdata[9] !== e.vis)
               note_mismatch("visible", 8'(e.vis), 8'(rsp_tdata[9]));
            if (rsp_tdata[17:10] !== e.ctype)
               note_mismatch("cell_type", e.ctype, rsp_tdata[17:10]);
            if (rsp_tdata[23:18] !== 6'd0)
               note_mismatch("pad bits", 8'h00, 8'(rsp_tdata[23:18]));
         end
      end
   end

   // watchdog: any beat on either side restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial idle_cycles = 0;

endmodule
